/* hw/rtl/c2p_pkg.sv */
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared types, widths and constants for the cartesian to polar CORDIC.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int COORD_WIDTH        = 16;
    localparam int OUT_WIDTH          = 16;
    localparam int ITERATIONS_DEFAULT = 16;
    localparam int GUARD_BITS         = 16;
    localparam int TABLE_LEN          = 32;

    // Datapath: sign, 17-bit coordinate after the quarter turn, gain growth,
    // margin, and the guard fraction bits.
    localparam int XW     = COORD_WIDTH + GUARD_BITS + 4;
    // Angle accumulator in Q30 radians; worst case is about 3.3 rad.
    localparam int ZW     = 34;
    localparam int GAIN_W = 30;
    localparam int PW     = XW - GUARD_BITS + GAIN_W;
    localparam int LW     = GUARD_BITS + GAIN_W;
    localparam int SW     = PW + 1;

    localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = GAIN_W'(652032874);
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
    localparam logic signed [OUT_WIDTH-1:0] ANGLE_LIMIT = OUT_WIDTH'(25736);
    localparam logic [OUT_WIDTH-1:0] MAG_MAX = '1;

    // atan(2^-i) in Q30
    localparam logic [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
        ZW'(32'h3243F6A8), ZW'(32'h1DAC6705), ZW'(32'h0FADBAFC), ZW'(32'h07F56EA6),
        ZW'(32'h03FEAB76), ZW'(32'h01FFD55B), ZW'(32'h00FFFAAA), ZW'(32'h007FFF55),
        ZW'(32'h003FFFEA), ZW'(32'h001FFFFD), ZW'(32'h000FFFFF), ZW'(32'h0007FFFF),
        ZW'(32'h0003FFFF), ZW'(32'h0001FFFF), ZW'(32'h0000FFFF), ZW'(32'h00007FFF),
        ZW'(32'h00003FFF), ZW'(32'h00001FFF), ZW'(32'h00000FFF), ZW'(32'h000007FF),
        ZW'(32'h000003FF), ZW'(32'h000001FF), ZW'(32'h000000FF), ZW'(32'h0000007F),
        ZW'(32'h0000003F), ZW'(32'h0000001F), ZW'(32'h0000000F), ZW'(32'h00000008),
        ZW'(32'h00000004), ZW'(32'h00000002), ZW'(32'h00000001), ZW'(32'h00000000)
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } point_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0]        magnitude;
        logic signed [OUT_WIDTH-1:0] angle;
    } polar_t;

    // One pipeline slot between rotation stages.
    typedef struct packed {
        logic                 valid;
        logic                 origin;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

endpackage

/* hw/rtl/c2p_prerot.sv */
// ----------------------------------------------------------------------------
// c2p_prerot
// Input register: quarter turn into the right half plane and guard scaling.
// ----------------------------------------------------------------------------
module c2p_prerot (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  c2p_pkg::point_t point,
    output c2p_pkg::lane_t  lane_out
);
    import c2p_pkg::*;

    logic                 valid_reg;
    logic                 origin_reg, origin_next;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [XW-1:0] xe, ye, xr, yr;

    always_comb
    begin
        xe = XW'(point.x_coord);
        ye = XW'(point.y_coord);
        origin_next = (point.x_coord == '0) && (point.y_coord == '0);
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                xr     = ye;
                yr     = -xe;
                z_next = HALF_PI_Q30;
            end
            else
            begin
                xr     = -ye;
                yr     = xe;
                z_next = -HALF_PI_Q30;
            end
        end
        else
        begin
            xr     = xe;
            yr     = ye;
            z_next = '0;
        end
        x_next = xr <<< GUARD_BITS;
        y_next = yr <<< GUARD_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        origin_reg <= origin_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
    end

    assign lane_out = '{valid: valid_reg, origin: origin_reg,
                        x: x_reg, y: y_reg, z: z_reg};

endmodule

/* hw/rtl/c2p_stage.sv */
// ----------------------------------------------------------------------------
// c2p_stage
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module c2p_stage #(
    parameter int STAGE = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  c2p_pkg::lane_t lane_in,
    output c2p_pkg::lane_t lane_out
);
    import c2p_pkg::*;

    localparam logic signed [ZW-1:0] STEP_ANGLE = ATAN_Q30[STAGE];

    logic                 valid_reg;
    logic                 origin_reg;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [XW-1:0] dx, dy;

    always_comb
    begin
        dx = lane_in.y >>> STAGE;
        dy = lane_in.x >>> STAGE;
        if (lane_in.y >= 0)
        begin
            x_next = lane_in.x + dx;
            y_next = lane_in.y - dy;
            z_next = lane_in.z + STEP_ANGLE;
        end
        else
        begin
            x_next = lane_in.x - dx;
            y_next = lane_in.y + dy;
            z_next = lane_in.z - STEP_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= lane_in.valid;
    end

    always_ff @(posedge clk)
    begin
        origin_reg <= lane_in.origin;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
    end

    assign lane_out = '{valid: valid_reg, origin: origin_reg,
                        x: x_reg, y: y_reg, z: z_reg};

endmodule

/* hw/rtl/c2p_post.sv */
// ----------------------------------------------------------------------------
// c2p_post
// Gain correction, magnitude rounding, angle rounding and clamping.
// Two register stages: products, then sum and output register.
// ----------------------------------------------------------------------------
module c2p_post (
    input  logic            clk,
    input  logic            rst_n,
    input  c2p_pkg::lane_t  lane_in,
    output logic            done,
    output c2p_pkg::polar_t polar
);
    import c2p_pkg::*;

    localparam int ZQW = ZW + 1 - 17;

    // stage A
    logic                        valid_a_reg;
    logic [PW-1:0]               prod_hi_reg, prod_hi_next;
    logic [GAIN_W-1:0]           prod_lo_reg, prod_lo_next;
    logic signed [OUT_WIDTH-1:0] angle_a_reg, angle_a_next;
    logic [XW-1:0]               ux;
    logic [LW-1:0]               lo_full;
    logic signed [ZW:0]          zsum;
    logic signed [ZQW-1:0]       zq;

    // stage B
    logic                        done_reg;
    polar_t                      polar_reg, polar_next;
    logic [SW-1:0]               sum;
    logic [SW-31:0]              mag_wide;

    always_comb
    begin
        ux = (lane_in.x < 0) ? '0 : XW'(lane_in.x);
        prod_hi_next = PW'(ux[XW-1:GUARD_BITS]) * PW'(INV_GAIN_Q30);
        lo_full      = LW'(ux[GUARD_BITS-1:0]) * LW'(INV_GAIN_Q30);
        prod_lo_next = lo_full[LW-1:GUARD_BITS];

        zsum = (ZW+1)'(lane_in.z) + (ZW+1)'(65536);
        zq   = ZQW'(zsum >>> 17);
        if (lane_in.origin)
            angle_a_next = '0;
        else if (zq > ZQW'(ANGLE_LIMIT))
            angle_a_next = ANGLE_LIMIT;
        else if (zq < -ZQW'(ANGLE_LIMIT))
            angle_a_next = -ANGLE_LIMIT;
        else
            angle_a_next = OUT_WIDTH'(zq);
    end

    always_comb
    begin
        sum = SW'(prod_hi_reg) + SW'(prod_lo_reg) + (SW'(1) << 29);
        mag_wide = sum[SW-1:30];
        if (mag_wide > (SW-30)'(MAG_MAX))
            polar_next.magnitude = MAG_MAX;
        else
            polar_next.magnitude = OUT_WIDTH'(mag_wide);
        polar_next.angle = angle_a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_a_reg <= lane_in.valid;
            done_reg    <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_hi_reg <= prod_hi_next;
        prod_lo_reg <= prod_lo_next;
        angle_a_reg <= angle_a_next;
        polar_reg   <= polar_next;
    end

    assign done  = done_reg;
    assign polar = polar_reg;

endmodule

/* hw/rtl/cartesian_to_polar_top.sv */
// ----------------------------------------------------------------------------
// cartesian_to_polar_top
// Fully pipelined CORDIC vectoring unit: (x, y) to (magnitude, atan2 angle).
// ----------------------------------------------------------------------------
// A new point may be issued every clock: busy never rises, because the
// result side has no back-pressure and nothing inside ever waits. Each word
// accepted with start comes back on polar with done high for a single
// cycle; results keep issue order. Its path is one input register (quarter
// turn), one register per micro-rotation, the gain-multiply register and
// the output register.
// Magnitude is rounded and gain-corrected in input units; angle is Q3.13
// radians, clamped to +/- pi; the origin returns zero for both.
// ----------------------------------------------------------------------------
module cartesian_to_polar_top #(
    parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  c2p_pkg::point_t point,
    output logic            done,
    output c2p_pkg::polar_t polar
);
    import c2p_pkg::*;

    localparam int LATENCY = ITERATIONS + 3;

    // lane[0] is the quarter-turned input, lane[i+1] follows rotation i
    lane_t lane [ITERATIONS+1];

    // Never stalls: one word in per clock, always.
    assign busy = 1'b0;

    c2p_prerot u_prerot (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (start && !busy),
        .point    (point),
        .lane_out (lane[0])
    );

    // One micro-rotation per register stage, shift amount fixed per stage.
    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_rot
        c2p_stage #(
            .STAGE (g)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .lane_in  (lane[g]),
            .lane_out (lane[g+1])
        );
    end

    // Gain correction and rounding; owns the output register.
    c2p_post u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .lane_in (lane[ITERATIONS]),
        .done    (done),
        .polar   (polar)
    );

    // Every accepted word produces exactly one result after a fixed delay.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing at expected latency");

    // No result without a matching accepted word.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted word");

    // Origin maps to zero angle and zero magnitude.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy && point.x_coord == '0
                       && point.y_coord == '0, LATENCY))
        |-> (polar.angle == '0 && polar.magnitude == '0))
        else $error("origin did not give zero result");

    // Angle stays within +/- pi in Q3.13.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (polar.angle <= ANGLE_LIMIT && polar.angle >= -ANGLE_LIMIT))
        else $error("angle out of range");

endmodule
